@@ sv/nfrq_pkg.sv @@
`timescale 1ns / 1ps

package nfrq_pkg;

  localparam int unsigned QueueSlotsDef = 8;
  localparam int unsigned SlotBytesDef  = 2048;

  localparam logic [11:0] SlotCapReset = 12'd2048;
  localparam logic [11:0] MinLenReset  = 12'd60;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_NO_ROOM      = 3'd2,
    ST_EMPTY        = 3'd3,
    ST_OUT_OF_RANGE = 3'd4
  } status_e;

  typedef enum logic {
    REG_SLOT_CAP = 1'b0,
    REG_MIN_LEN  = 1'b1
  } reg_e;

  typedef struct packed {
    logic [11:0] slot_capacity;
    logic [11:0] min_frame_length;
  } cfg_t;

endpackage

@@ sv/nfrq_ram.sv @@
`timescale 1ns / 1ps

module nfrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/nfrq_cfg.sv @@
`timescale 1ns / 1ps

module nfrq_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output nfrq_pkg::cfg_t      cfg_o
);

  import nfrq_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_e'(paddr[2]))
        REG_SLOT_CAP: cfg_d.slot_capacity    = pwdata[11:0];
        REG_MIN_LEN:  cfg_d.min_frame_length = pwdata[11:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_capacity    <= SlotCapReset;
      cfg_q.min_frame_length <= MinLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_SLOT_CAP: prdata = {20'd0, cfg_q.slot_capacity};
      REG_MIN_LEN:  prdata = {20'd0, cfg_q.min_frame_length};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/nic_frame_ring_queue.sv @@
`timescale 1ns / 1ps
// Latency: a request accepted at one edge has its result beat on the outputs, with done_o,
// during the following cycle. Throughput: one request per cycle; busy stays low, since
// queue state updates at acceptance and only the frame and length memory reads trail, landing with the result beat.
// Reset clears pointers, frame count, write offset and the length valid bits; frame memory
// is not cleared. The receiver cannot stall results.
module nic_frame_ring_queue #(
  parameter int unsigned QUEUE_SLOTS = nfrq_pkg::QueueSlotsDef,
  parameter int unsigned SLOT_BYTES  = nfrq_pkg::SlotBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [2:0]  slot_index_i,
  input  logic [10:0] byte_offset_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [7:0]  read_byte_o,
  output logic [2:0]  frame_slot_o,
  output logic [11:0] frame_length_o,
  output logic [3:0]  occupancy_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import nfrq_pkg::*;

  localparam int unsigned SlotW  = $clog2(QUEUE_SLOTS);
  localparam int unsigned CntW   = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned Depth  = QUEUE_SLOTS * SLOT_BYTES;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CapW0  = $clog2(SLOT_BYTES + 1);
  localparam int unsigned CapW   = (CapW0 > 13) ? CapW0 : 13;

  cfg_t cfg;

  logic [SlotW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [11:0]            wr_off_q, wr_off_d;
  logic [QUEUE_SLOTS-1:0] valid_q;

  logic             s_valid_q;
  req_e             s_req_q;
  status_e          s_status_q;
  logic [2:0]       s_slot_q;
  logic [10:0]      s_off_q;
  logic             s_oor_q;
  logic             s_lvalid_q;
  logic [CntW-1:0]  s_occ_q;

  logic             acc, full, clr, lm_we, fm_we, rd_oor, lvalid;
  req_e             req;
  status_e          st;
  logic [CapW-1:0]  cap_eff;
  logic [11:0]      n_len;
  logic [SlotW-1:0] rd_slot, head_nxt, tail_nxt, lm_raddr;
  logic [AddrW-1:0] fm_waddr, fm_raddr;
  logic [7:0]       fm_rdata;
  logic [11:0]      lm_rdata, len;
  status_e          out_status;

  nfrq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy    = 1'b0;
  assign acc     = start & ~busy;
  assign req     = req_e'(req_type_i);
  assign full    = (count_q == CntW'(QUEUE_SLOTS));
  assign cap_eff = (CapW'(cfg.slot_capacity) > CapW'(SLOT_BYTES)) ? CapW'(SLOT_BYTES)
                                                                   : CapW'(cfg.slot_capacity);
  assign n_len   = (wr_off_q == 12'hFFF) ? 12'hFFF : wr_off_q + 12'd1;

  assign head_nxt = (head_q == SlotW'(QUEUE_SLOTS - 1)) ? '0 : head_q + SlotW'(1);
  assign tail_nxt = (tail_q == SlotW'(QUEUE_SLOTS - 1)) ? '0 : tail_q + SlotW'(1);

  assign rd_slot  = SlotW'(slot_index_i);
  assign rd_oor   = (int'(slot_index_i) >= QUEUE_SLOTS);
  assign lm_raddr = (req == REQ_POP) ? head_q : rd_slot;
  assign lvalid   = (req == REQ_POP) ? valid_q[head_q] : (!rd_oor && valid_q[rd_slot]);

  assign fm_waddr = AddrW'(tail_q) * AddrW'(SLOT_BYTES) + AddrW'(wr_off_q);
  assign fm_raddr = AddrW'(rd_slot) * AddrW'(SLOT_BYTES) + AddrW'(byte_offset_i);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    wr_off_d = wr_off_q;
    fm_we    = 1'b0;
    lm_we    = 1'b0;
    clr      = 1'b0;
    st       = ST_OK;
    if (acc) begin
      case (req)
        REQ_PUSH: begin
          fm_we = !full && (CapW'(wr_off_q) < cap_eff);
          if (last_byte_i) begin
            wr_off_d = '0;
            if (n_len < cfg.min_frame_length) begin
              st = ST_TOO_SHORT;
            end else if (full || (CapW'(n_len) > cap_eff)) begin
              st = ST_NO_ROOM;
            end else begin
              lm_we   = 1'b1;
              tail_d  = tail_nxt;
              count_d = count_q + CntW'(1);
            end
          end else begin
            wr_off_d = n_len;
          end
        end
        REQ_POP: begin
          if (count_q == '0) begin
            st = ST_EMPTY;
          end else begin
            head_d  = head_nxt;
            count_d = count_q - CntW'(1);
          end
        end
        REQ_READ: begin
          st = ST_OK;
        end
        REQ_CLEAR: begin
          clr      = 1'b1;
          head_d   = '0;
          tail_d   = '0;
          count_d  = '0;
          wr_off_d = '0;
        end
        default: st = ST_OK;
      endcase
    end
  end

  nfrq_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (fm_waddr),
    .wdata_i (data_byte_i),
    .raddr_i (fm_raddr),
    .rdata_o (fm_rdata)
  );

  nfrq_ram #(
    .Width (12),
    .Depth (QUEUE_SLOTS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (lm_we),
    .waddr_i (tail_q),
    .wdata_i (n_len),
    .raddr_i (lm_raddr),
    .rdata_o (lm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      wr_off_q  <= '0;
      valid_q   <= '0;
      s_valid_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      wr_off_q  <= wr_off_d;
      s_valid_q <= acc;
      if (clr) begin
        valid_q <= '0;
      end else if (lm_we) begin
        valid_q[tail_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s_req_q    <= req;
      s_status_q <= st;
      s_slot_q   <= 3'(head_q);
      s_off_q    <= byte_offset_i;
      s_oor_q    <= rd_oor;
      s_lvalid_q <= lvalid;
      s_occ_q    <= count_d;
    end
  end

  // an entry without its valid bit reads as zero length
  assign len = s_lvalid_q ? lm_rdata : 12'd0;

  always_comb begin
    out_status     = s_status_q;
    read_byte_o    = 8'd0;
    frame_slot_o   = 3'd0;
    frame_length_o = 12'd0;
    case (s_req_q)
      REQ_READ: begin
        if (s_oor_q || ({1'b0, s_off_q} >= len)) begin
          out_status = ST_OUT_OF_RANGE;
        end else begin
          out_status  = ST_OK;
          read_byte_o = fm_rdata;
        end
      end
      REQ_POP: begin
        if (s_status_q == ST_OK) begin
          frame_slot_o   = s_slot_q;
          frame_length_o = len;
        end
      end
      default: out_status = s_status_q;
    endcase
  end

  assign done_o      = s_valid_q;
  assign status_o    = out_status;
  assign occupancy_o = 4'(s_occ_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_SLOTS))
    else $error("frame count above slot count");

  a_ptr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CntW'(QUEUE_SLOTS)) |-> head_q == tail_q)
    else $error("head and tail disagree with frame count");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> done_o)
    else $error("accepted request without result beat");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req == REQ_POP && count_q == '0) |=>
      (status_o == ST_EMPTY && occupancy_o == 4'd0))
    else $error("pop on empty queue not reported");

endmodule

@@ test/nic_frame_ring_queue_tb.sv @@
`timescale 1ns / 1ps

module nic_frame_ring_queue_tb;
  import nfrq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [2:0]  st;
    logic [7:0]  rb;
    logic [2:0]  fs;
    logic [11:0] fl;
    logic [3:0]  occ;
  } beat_t;

  typedef struct packed {
    req_e        req;
    logic [7:0]  dat;
    logic        lst;
    logic [2:0]  slot;
    logic [10:0] ofs;
    logic        pin;
    beat_t       want;
  } dir_row_t;

  // rows 0..3 run with reset settings, rows 4..24 with capacity 3 and minimum 1
  localparam dir_row_t DIR_TBL [25] = '{
    '{REQ_POP,   8'h00, 1'b0, 3'd0, 11'd0,    1'b1, '{ST_EMPTY,        8'h0, 3'd0, 12'd0, 4'd0}},
    '{REQ_READ,  8'h00, 1'b0, 3'd0, 11'd0,    1'b1, '{ST_OUT_OF_RANGE, 8'h0, 3'd0, 12'd0, 4'd0}},
    '{REQ_PUSH,  8'h80, 1'b1, 3'd0, 11'd0,    1'b1, '{ST_TOO_SHORT,    8'h0, 3'd0, 12'd0, 4'd0}},
    '{REQ_CLEAR, 8'h00, 1'b0, 3'd0, 11'd0,    1'b1, '{ST_OK,           8'h0, 3'd0, 12'd0, 4'd0}},
    '{REQ_PUSH,  8'hFF, 1'b1, 3'd7, 11'd2047, 1'b1, '{ST_OK,           8'h0, 3'd0, 12'd0, 4'd1}},
    '{REQ_PUSH,  8'h00, 1'b0, 3'd0, 11'd0,    1'b1, '{ST_OK,           8'h0, 3'd0, 12'd0, 4'd1}},
    '{REQ_PUSH,  8'h55, 1'b0, 3'd5, 11'd1365, 1'b1, '{ST_OK,           8'h0, 3'd0, 12'd0, 4'd1}},
    '{REQ_PUSH,  8'hAA, 1'b0, 3'd2, 11'd682,  1'b1, '{ST_OK,           8'h0, 3'd0, 12'd0, 4'd1}},
    '{REQ_PUSH,  8'h01, 1'b1, 3'd0, 11'd0,    1'b1, '{ST_NO_ROOM,      8'h0, 3'd0, 12'd0, 4'd1}},
    '{REQ_READ,  8'h00, 1'b0, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_READ,  8'h00, 1'b0, 3'd0, 11'd1,    1'b1, '{ST_OUT_OF_RANGE, 8'h0, 3'd0, 12'd0, 4'd1}},
    '{REQ_READ,  8'hFF, 1'b1, 3'd7, 11'd2047, 1'b1, '{ST_OUT_OF_RANGE, 8'h0, 3'd0, 12'd0, 4'd1}},
    '{REQ_PUSH,  8'h11, 1'b1, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_PUSH,  8'h22, 1'b1, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_PUSH,  8'h33, 1'b1, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_PUSH,  8'h44, 1'b1, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_PUSH,  8'h55, 1'b1, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_PUSH,  8'h66, 1'b1, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_PUSH,  8'h77, 1'b1, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_PUSH,  8'h12, 1'b1, 3'd0, 11'd0,    1'b1, '{ST_NO_ROOM,      8'h0, 3'd0, 12'd0, 4'd8}},
    '{REQ_POP,   8'h00, 1'b0, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_READ,  8'h00, 1'b0, 3'd0, 11'd0,    1'b0, '0},
    '{REQ_CLEAR, 8'hFF, 1'b1, 3'd7, 11'd2047, 1'b1, '{ST_OK,           8'h0, 3'd0, 12'd0, 4'd0}},
    '{REQ_POP,   8'h00, 1'b0, 3'd0, 11'd0,    1'b1, '{ST_EMPTY,        8'h0, 3'd0, 12'd0, 4'd0}},
    '{REQ_READ,  8'h00, 1'b0, 3'd1, 11'd0,    1'b1, '{ST_OUT_OF_RANGE, 8'h0, 3'd0, 12'd0, 4'd0}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic [2:0]  slot_index_i = '0;
  logic [10:0] byte_offset_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [7:0]  read_byte_o;
  logic [2:0]  frame_slot_o;
  logic [11:0] frame_length_o;
  logic [3:0]  occupancy_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nic_frame_ring_queue u_top (
    .clk_i, .rst_ni, .start, .busy,
    .req_type_i, .data_byte_i, .last_byte_i, .slot_index_i, .byte_offset_i,
    .done_o, .status_o, .read_byte_o, .frame_slot_o, .frame_length_o, .occupancy_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  // shadow of the ring
  logic [7:0]  ring_mem [0:16383];
  bit          ring_written [0:16383];
  logic [11:0] ring_len [0:7];
  logic [2:0]  ring_head, ring_tail;
  logic [3:0]  ring_cnt;
  logic [11:0] ring_wofs;
  logic [11:0] cap_reg = SlotCapReset;
  logic [11:0] min_reg = MinLenReset;

  beat_t       want_q [$];
  logic        pin_en = 1'b0;
  beat_t       pin_want = '0;
  int          errors = 0;
  int unsigned sent_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned cycles = 0;

  initial begin
    ring_head = '0;
    ring_tail = '0;
    ring_cnt  = '0;
    ring_wofs = '0;
    for (int i = 0; i < 8; i++) ring_len[i] = '0;
    for (int i = 0; i < 16384; i++) ring_written[i] = 1'b0;
  end

  function automatic beat_t ring_predict(req_e rq, logic [7:0] dat, logic lst,
                                         logic [2:0] slot, logic [10:0] ofs);
    beat_t       b;
    logic        full;
    logic [11:0] cap, n;
    b = '0;
    b.st = ST_OK;
    full = (ring_cnt >= 4'd8);
    cap = (cap_reg > 12'd2048) ? 12'd2048 : cap_reg;
    case (rq)
      REQ_PUSH: begin
        if (!full && ring_wofs < cap) begin
          ring_mem[{ring_tail, ring_wofs[10:0]}] = dat;
          ring_written[{ring_tail, ring_wofs[10:0]}] = 1'b1;
        end
        n = (ring_wofs < 12'hFFF) ? ring_wofs + 12'd1 : 12'hFFF;
        if (!lst) begin
          ring_wofs = n;
        end else begin
          if (n < min_reg) begin
            b.st = ST_TOO_SHORT;
          end else if (full || n > cap) begin
            b.st = ST_NO_ROOM;
          end else begin
            ring_len[ring_tail] = n;
            ring_tail = ring_tail + 3'd1;
            ring_cnt = ring_cnt + 4'd1;
          end
          ring_wofs = '0;
        end
      end
      REQ_POP: begin
        if (ring_cnt == 0) begin
          b.st = ST_EMPTY;
        end else begin
          b.fs = ring_head;
          b.fl = ring_len[ring_head];
          ring_head = ring_head + 3'd1;
          ring_cnt = ring_cnt - 4'd1;
        end
      end
      REQ_READ: begin
        if ({1'b0, ofs} >= ring_len[slot]) b.st = ST_OUT_OF_RANGE;
        else b.rb = ring_mem[{slot, ofs}];
      end
      default: begin
        ring_head = '0;
        ring_tail = '0;
        ring_cnt  = '0;
        ring_wofs = '0;
        for (int i = 0; i < 8; i++) ring_len[i] = '0;
      end
    endcase
    b.occ = ring_cnt;
    return b;
  endfunction

  always @(posedge clk_i) begin
    beat_t got, want, pred;
    if (rst_ni) begin
      if (done_o) begin
        got = '{status_o, read_byte_o, frame_slot_o, frame_length_o, occupancy_o};
        if (want_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, actual %p", $time, got);
        end else begin
          want = want_q.pop_front();
          if (got.st !== want.st || got.rb !== want.rb || got.fs !== want.fs ||
              got.fl !== want.fl || got.occ !== want.occ) begin
            errors++;
            $display("%0t: status exp %0d act %0d, byte exp %h act %h, slot exp %0d act %0d",
                     $time, want.st, got.st, want.rb, got.rb, want.fs, got.fs);
            $display("%0t: length exp %0d act %0d, occupancy exp %0d act %0d",
                     $time, want.fl, got.fl, want.occ, got.occ);
          end
        end
      end
      if (start && !busy) begin
        pred = ring_predict(req_e'(req_type_i), data_byte_i, last_byte_i,
                            slot_index_i, byte_offset_i);
        want_q.push_back(pin_en ? pin_want : pred);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // every task starts and ends on a falling edge
  task automatic drive_req(req_e rq, logic [7:0] dat, logic lst, logic [2:0] slot,
                           logic [10:0] ofs, logic pin, beat_t want);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    pin_en = pin;
    pin_want = want;
    start = 1'b1;
    req_type_i = rq;
    data_byte_i = dat;
    last_byte_i = lst;
    slot_index_i = slot;
    byte_offset_i = ofs;
    do @(posedge clk_i); while (busy);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start = 1'b0;
    while (want_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic apb_xfer(logic wr, logic [2:0] addr, logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_cfg(logic [11:0] cap, logic [11:0] minl);
    logic [31:0] rd;
    logic [11:0] val;
    logic [2:0]  addr;
    for (int k = 0; k < 2; k++) begin
      val = k ? minl : cap;
      addr = k ? {REG_MIN_LEN, 2'b00} : {REG_SLOT_CAP, 2'b00};
      apb_xfer(1'b1, addr, {20'd0, val}, rd);
      apb_xfer(1'b0, addr, '0, rd);
      if (rd[11:0] !== val) begin
        errors++;
        $display("%0t: register %0d readback exp %0d act %0d", $time, addr, val, rd[11:0]);
      end
    end
    cap_reg = cap;
    min_reg = minl;
  endtask

  // reads never touch a stored position that was never written
  task automatic send_read(logic valid_only);
    logic [2:0]  s;
    logic [10:0] o;
    req_e        rq;
    rq = REQ_READ;
    s = 3'($urandom_range(7));
    o = 11'($urandom_range(2047));
    if (valid_only) begin
      if (ring_len[s] == 0) s = ring_tail - 3'd1;
      if (ring_len[s] != 0) o = 11'($urandom_range(ring_len[s] - 1));
    end else if ($urandom_range(1)) begin
      o = ring_len[s][10:0] - 11'($urandom_range(1));
    end
    if ({1'b0, o} < ring_len[s] && !ring_written[{s, o}]) begin
      if (ring_len[s] < 12'd2048) o = ring_len[s][10:0];
      else rq = REQ_POP;
    end
    drive_req(rq, 8'($urandom), 1'($urandom), s, o, 1'b0, '0);
  endtask

  task automatic push_frame(int unsigned len, int unsigned mix_pct);
    for (int unsigned i = 1; i <= len; i++) begin
      if ($urandom_range(99) < mix_pct) begin
        if ($urandom_range(1)) drive_req(REQ_POP, 8'($urandom), 1'($urandom),
                                         3'($urandom), 11'($urandom), 1'b0, '0);
        else send_read(1'($urandom_range(1)));
      end
      drive_req(REQ_PUSH, 8'($urandom), i == len, 3'($urandom), 11'($urandom), 1'b0, '0);
    end
  endtask

  task automatic run_phase(logic [11:0] cap, logic [11:0] minl, int unsigned idle,
                           int unsigned n_items, bit hold_off);
    int unsigned stop, r;
    int          len;
    bit          paused;
    drain();
    set_cfg(cap, minl);
    idle_pct = idle;
    stop = sent_cnt + n_items;
    paused = 0;
    while (sent_cnt < stop) begin
      if (hold_off && !paused && sent_cnt >= stop - n_items / 2) begin
        drain();
        paused = 1;
      end
      r = $urandom_range(99);
      if (r < 30) begin
        drive_req(REQ_POP, 8'($urandom), 1'($urandom), 3'($urandom), 11'($urandom),
                  1'b0, '0);
      end else if (r < 50) begin
        send_read(1'($urandom_range(1)));
      end else if (r < 56) begin
        r = $urandom_range(3);
        if (req_e'(r) == REQ_READ) send_read(1'b0);
        else drive_req(req_e'(r), 8'($urandom), 1'($urandom), 3'($urandom),
                       11'($urandom), 1'b0, '0);
      end else if (r < 58) begin
        drive_req(REQ_CLEAR, 8'($urandom), 1'($urandom), 3'($urandom), 11'($urandom),
                  1'b0, '0);
      end else begin
        case ($urandom_range(5))
          0: len = int'(min_reg) - 1;
          1: len = int'(min_reg);
          2: len = int'((cap_reg > 12'd2048) ? 12'd2048 : cap_reg);
          3: len = int'((cap_reg > 12'd2048) ? 12'd2048 : cap_reg) + 1;
          default: len = 0;
        endcase
        if (len < 1 || len > 40) len = 1 + int'($urandom_range(11));
        push_frame(len, 10);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 25; i++) begin
      if (i == 4) begin
        drain();
        set_cfg(12'd3, 12'd1);
      end
      drive_req(DIR_TBL[i].req, DIR_TBL[i].dat, DIR_TBL[i].lst, DIR_TBL[i].slot,
                DIR_TBL[i].ofs, DIR_TBL[i].pin, DIR_TBL[i].want);
    end
    pin_en = 1'b0;

    run_phase(12'd8, 12'd2, 0, 250, 0);
    run_phase(12'd1, 12'd0, 62, 150, 0);
    run_phase(12'd0, 12'd0, 38, 100, 0);
    run_phase(12'hFFF, 12'd3, 62, 250, 0);

    // frame at slot capacity, one byte over, one byte short of the minimum, then reads
    drain();
    set_cfg(12'd64, 12'd64);
    idle_pct = 0;
    drive_req(REQ_CLEAR, 8'($urandom), 1'($urandom), 3'($urandom), 11'($urandom), 1'b0, '0);
    push_frame(64, 0);
    push_frame(65, 0);
    push_frame(63, 0);
    repeat (40) send_read(1'b1);

    run_phase(12'd5, 12'd1, 38, 400, 1);

    start = 1'b0;
    while (want_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
